// ===== rtl/vrc6_pkg.sv =====
// shared types, codes and tables for the vrc6 mapper bank and scanline irq block
package vrc6_pkg;

    typedef struct packed {
        logic        opcode;
        logic [15:0] cpu_addr;
        logic [7:0]  write_data;
    } in_beat_t;

    typedef struct packed {
        logic        irq_raise;
        logic [2:0]  update_kind;
        logic [2:0]  chr_slot;
        logic [8:0]  page;
        logic [1:0]  mirroring;
        logic [15:0] sound_addr;
        logic [7:0]  sound_data;
        logic        sound_write;
    } out_beat_t;

    // irq register commands from the write decoder
    typedef struct packed {
        logic       tick;
        logic       set_reload;
        logic       set_enable_lo;
        logic       set_enable_full;
        logic [7:0] data;
    } irq_cmd_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_PRG_PAIR = 3'd1;
    localparam logic [2:0] KIND_PRG_C000 = 3'd2;
    localparam logic [2:0] KIND_CHR    = 3'd3;
    localparam logic [2:0] KIND_MIRROR = 3'd4;

    localparam logic [1:0] MIR_SINGLE_HIGH = 2'd0;
    localparam logic [1:0] MIR_VERTICAL    = 2'd1;
    localparam logic [1:0] MIR_HORIZONTAL  = 2'd2;
    localparam logic [1:0] MIR_SINGLE_LOW  = 2'd3;

    localparam logic [15:0] ADDR_PRG_PAIR   = 16'h8000;
    localparam logic [15:0] ADDR_PRG_C000   = 16'hC000;
    localparam logic [15:0] ADDR_CHR_LO     = 16'hD000;
    localparam logic [15:0] ADDR_CHR_HI     = 16'hE000;
    localparam logic [15:0] ADDR_MIRROR     = 16'hB003;
    localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_EN_LO  = 16'hF001;
    localparam logic [15:0] ADDR_IRQ_EN     = 16'hF002;
    localparam logic [15:0] ADDR_GROUP_MASK = 16'hFFFC;

    localparam logic [7:0] MIR_DATA_MASK  = 8'h7F;
    localparam logic [7:0] MIR_CODE_SH_A  = 8'h08;
    localparam logic [7:0] MIR_CODE_SH_B  = 8'h2C;
    localparam logic [7:0] MIR_CODE_VERT  = 8'h20;
    localparam logic [7:0] MIR_CODE_HORZ  = 8'h24;
    localparam logic [7:0] MIR_CODE_SL    = 8'h28;

    localparam logic [7:0] IRQ_COUNT_TOP  = 8'hFE;

    // register index within the d/e groups to character slot
    localparam logic [2:0] CHR_SLOT_OF [8] = '{
        3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd6, 3'd5, 3'd7
    };

endpackage

// ===== rtl/vrc6_bank_and_scanline_irq.sv =====
// top level of the vrc6 mapper bank and scanline irq block
// The block takes one input beat per clock (a cpu register write or a scanline
// tick) and returns exactly one result beat for each, in order. A beat goes
// through an input register, one pass of decode and irq logic, and a result
// register; the sustained rate is one beat per cycle, limited only by out_ready.
// Each result beat reports the bank, character slot or mirroring update the
// write caused; the downstream page logic keeps the bank values itself from
// these beats, so only the irq latch, enable and counter are held here. Every
// cpu write is echoed on the sound fields with address bits 0 and 1 swapped.
// Data to B003 is echoed with bit 7 cleared. No clearing pass follows reset.
module vrc6_bank_and_scanline_irq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vrc6_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vrc6_pkg::out_beat_t out_data
);

    // input register stage
    logic                s1_valid_reg, s1_valid_next;
    vrc6_pkg::in_beat_t  s1_data_reg,  s1_data_next;

    // result register stage
    logic                out_valid_reg, out_valid_next;
    vrc6_pkg::out_beat_t out_data_reg,  out_data_next;

    logic                in_take;
    logic                advance;
    logic                irq_raise;
    vrc6_pkg::out_beat_t result;
    vrc6_pkg::irq_cmd_t  irq_cmd;

    // the staged beat moves into the result register when that slot is free
    // or being drained this cycle; irq state updates at the same edge
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    vrc6_decode u_decode
    (
        .beat      (s1_data_reg),
        .irq_raise (irq_raise),
        .result    (result),
        .irq_cmd   (irq_cmd)
    );

    vrc6_irq u_irq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cmd   (irq_cmd),
        .raise (irq_raise)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_data_next   = s1_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
            s1_data_next  = in_data;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // with the result slot empty the block always takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // an irq only comes from a tick, never alongside a forwarded write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.irq_raise && out_data_reg.sound_write))
        else $error("irq raised on a cpu write beat");

endmodule

// ===== rtl/vrc6_decode.sv =====
// write address decode and result beat assembly
module vrc6_decode
(
    input  vrc6_pkg::in_beat_t  beat,
    input  logic                irq_raise,
    output vrc6_pkg::out_beat_t result,
    output vrc6_pkg::irq_cmd_t  irq_cmd
);

    logic        is_write;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  mir_data;
    logic        hit_chr;
    logic [2:0]  chr_idx;

    assign is_write = (beat.opcode == vrc6_pkg::OP_WRITE);
    assign addr     = beat.cpu_addr;
    assign data     = beat.write_data;
    assign mir_data = data & vrc6_pkg::MIR_DATA_MASK;
    assign hit_chr  = ((addr & vrc6_pkg::ADDR_GROUP_MASK) == vrc6_pkg::ADDR_CHR_LO)
                   || ((addr & vrc6_pkg::ADDR_GROUP_MASK) == vrc6_pkg::ADDR_CHR_HI);
    assign chr_idx  = {(addr[15:12] == vrc6_pkg::ADDR_CHR_HI[15:12]), addr[1:0]};

    always_comb
    begin
        result             = '0;
        irq_cmd            = '0;
        irq_cmd.data       = data;
        irq_cmd.tick       = !is_write;
        result.irq_raise   = irq_raise;
        if (is_write)
        begin
            result.sound_write = 1'b1;
            result.sound_addr  = {addr[15:2], addr[0], addr[1]};
            result.sound_data  = (addr == vrc6_pkg::ADDR_MIRROR) ? mir_data : data;
            priority if (addr == vrc6_pkg::ADDR_PRG_PAIR)
            begin
                result.update_kind = vrc6_pkg::KIND_PRG_PAIR;
                result.page        = {data, 1'b0};
            end
            else if (addr == vrc6_pkg::ADDR_PRG_C000)
            begin
                result.update_kind = vrc6_pkg::KIND_PRG_C000;
                result.page        = {1'b0, data};
            end
            else if (hit_chr)
            begin
                result.update_kind = vrc6_pkg::KIND_CHR;
                result.chr_slot    = vrc6_pkg::CHR_SLOT_OF[chr_idx];
                result.page        = {1'b0, data};
            end
            else if (addr == vrc6_pkg::ADDR_MIRROR)
            begin
                priority if (mir_data == vrc6_pkg::MIR_CODE_SH_A
                          || mir_data == vrc6_pkg::MIR_CODE_SH_B)
                begin
                    result.update_kind = vrc6_pkg::KIND_MIRROR;
                    result.mirroring   = vrc6_pkg::MIR_SINGLE_HIGH;
                end
                else if (mir_data == vrc6_pkg::MIR_CODE_VERT)
                begin
                    result.update_kind = vrc6_pkg::KIND_MIRROR;
                    result.mirroring   = vrc6_pkg::MIR_VERTICAL;
                end
                else if (mir_data == vrc6_pkg::MIR_CODE_HORZ)
                begin
                    result.update_kind = vrc6_pkg::KIND_MIRROR;
                    result.mirroring   = vrc6_pkg::MIR_HORIZONTAL;
                end
                else if (mir_data == vrc6_pkg::MIR_CODE_SL)
                begin
                    result.update_kind = vrc6_pkg::KIND_MIRROR;
                    result.mirroring   = vrc6_pkg::MIR_SINGLE_LOW;
                end
                else
                begin
                    // unlisted code, mode unchanged
                    result.update_kind = vrc6_pkg::KIND_NONE;
                end
            end
            else if (addr == vrc6_pkg::ADDR_IRQ_RELOAD)
            begin
                irq_cmd.set_reload = 1'b1;
            end
            else if (addr == vrc6_pkg::ADDR_IRQ_EN_LO)
            begin
                irq_cmd.set_enable_lo = 1'b1;
            end
            else if (addr == vrc6_pkg::ADDR_IRQ_EN)
            begin
                irq_cmd.set_enable_full = 1'b1;
            end
            else
            begin
                result.update_kind = vrc6_pkg::KIND_NONE;
            end
        end
    end

endmodule

// ===== rtl/vrc6_irq.sv =====
// scanline irq latch, enable and counter
module vrc6_irq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  vrc6_pkg::irq_cmd_t cmd,
    output logic               raise
);

    logic [7:0] reload_reg, reload_next;
    logic [1:0] enable_reg, enable_next;
    logic [7:0] count_reg,  count_next;
    logic       at_top;

    assign at_top = (count_reg >= vrc6_pkg::IRQ_COUNT_TOP);
    assign raise  = cmd.tick && (enable_reg != 2'd0) && at_top;

    always_comb
    begin
        reload_next = reload_reg;
        enable_next = enable_reg;
        count_next  = count_reg;
        if (step)
        begin
            if (cmd.tick)
            begin
                if (enable_reg != 2'd0)
                begin
                    if (at_top)
                    begin
                        count_next  = reload_reg;
                        enable_next = 2'd0;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
            end
            else
            begin
                if (cmd.set_reload)
                begin
                    reload_next = cmd.data;
                end
                if (cmd.set_enable_lo)
                begin
                    enable_next = {1'b0, cmd.data[0]};
                end
                if (cmd.set_enable_full)
                begin
                    enable_next = cmd.data[1:0];
                    if (cmd.data[1])
                    begin
                        count_next = reload_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            enable_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            reload_reg <= reload_next;
            enable_reg <= enable_next;
            count_reg  <= count_next;
        end
    end

    // a raised irq leaves the counter disabled and reloaded
    assert property (@(posedge clk) disable iff (!rst_n)
        step && raise |=> enable_reg == 2'd0 && count_reg == $past(reload_reg))
        else $error("irq raise did not disable and reload");

    // reload-on-enable copies the latch
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !cmd.tick && cmd.set_enable_full && cmd.data[1]
        |=> count_reg == $past(reload_reg))
        else $error("enable write with reload did not load the counter");

    // a tick with the counter disabled changes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        step && cmd.tick && enable_reg == 2'd0
        |=> $stable(count_reg) && $stable(enable_reg))
        else $error("disabled counter moved on a tick");

endmodule
